[hw/rtl/rgbc_pkg.sv]
package rgbc_pkg;

    localparam int LINE_MAX_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int KERNEL = 3;
    localparam int PIXEL_MAX = 255;
    localparam logic [10:0] HEIGHT_CAP = 11'd1024;
    localparam logic [10:0] ROW_CAP = 11'd2047;

    localparam logic [2:0] REG_FRAME_WIDTH = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_COEF_TOP = 3'd2;
    localparam logic [2:0] REG_COEF_MID = 3'd3;
    localparam logic [2:0] REG_COEF_BOTTOM = 3'd4;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [10:0] FRAME_WIDTH_RST = 11'd1024;
    localparam logic [10:0] FRAME_HEIGHT_RST = 11'd1024;
    localparam logic [47:0] COEF_TOP_RST = 48'd0;
    localparam logic [47:0] COEF_MID_RST = 48'h0000_0100_0000;
    localparam logic [47:0] COEF_BOTTOM_RST = 48'd0;

    typedef struct packed {
        logic       op;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_out;

    // one classified item handed from front to back
    typedef struct packed {
        logic        proc;
        logic        primed;
        logic        rv0;
        logic        rv2;
        logic        cv0;
        logic        cv2;
        logic        last;
        logic [23:0] pix;
    } t_op;

endpackage

[hw/rtl/rgbc_line_mem.sv]
module rgbc_line_mem #(
    parameter int DEPTH = rgbc_pkg::LINE_MAX_DEF,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [47:0]   i_wr_data,
    output logic [47:0]   o_rd_data
);

    // entry holds {upper line, middle line}
    logic [47:0] r_mem [DEPTH];
    logic [47:0] r_rd;
    logic [47:0] r_byp_data;
    logic        r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
        r_byp_data <= i_wr_data;
    end

    // a read colliding with the write in the same cycle takes the new data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd;

endmodule

[hw/rtl/rgbc_front.sv]
module rgbc_front #(
    parameter int LINE_MAX = rgbc_pkg::LINE_MAX_DEF,
    parameter int QUEUE_DEPTH = rgbc_pkg::QUEUE_DEPTH_DEF,
    parameter int CW = $clog2(LINE_MAX),
    parameter int KW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  rgbc_pkg::t_in    i_data,
    output logic             o_stall,
    input  logic             i_pop,
    input  logic [10:0]      i_frame_width,
    input  logic [10:0]      i_frame_height,
    output logic             o_rd_en,
    output logic [CW-1:0]    o_rd_addr,
    output rgbc_pkg::t_op    o_op,
    output logic [CW-1:0]    o_col,
    output logic [KW-1:0]    o_credit
);

    localparam int EW = ($clog2(LINE_MAX + 1) > 11) ? $clog2(LINE_MAX + 1) : 11;

    logic [CW-1:0] r_in_col, n_in_col;
    logic [10:0]   r_in_row, n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [9:0]    r_out_row, n_out_row;
    logic [KW-1:0] r_credit;
    rgbc_pkg::t_op r_op, n_op;
    logic [CW-1:0] r_col;

    logic [EW-1:0] fw, w;
    logic [10:0]   h;
    logic          acc, done, in_wrap, out_wrap, primed, last, proc;

    always_comb begin
        fw = EW'(i_frame_width);
        if (fw == '0) w = EW'(1);
        else if (fw > EW'(LINE_MAX)) w = EW'(LINE_MAX);
        else w = fw;
        if (i_frame_height == 11'd0) h = 11'd1;
        else if (i_frame_height > rgbc_pkg::HEIGHT_CAP) h = rgbc_pkg::HEIGHT_CAP;
        else h = i_frame_height;
    end

    assign o_stall = (r_credit >= KW'(QUEUE_DEPTH));
    assign acc = i_valid && !o_stall;
    assign done = (r_in_row >= h);
    // drain items are dropped while frame pixels are still due
    assign proc = acc && !((i_data.op == rgbc_pkg::OP_DRAIN) && !done);
    assign primed = (r_in_row >= 11'd2) || ((r_in_row == 11'd1) && (r_in_col != '0));
    assign in_wrap = (EW'(r_in_col) + EW'(1)) >= w;
    assign out_wrap = (EW'(r_out_col) + EW'(1)) >= w;
    assign last = ((11'(r_out_row) + 11'd1) >= h) && out_wrap;

    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_op.proc = proc;
        n_op.primed = primed;
        n_op.rv0 = (r_out_row != 10'd0);
        n_op.rv2 = (11'(r_out_row) + 11'd1) < h;
        n_op.cv0 = (r_out_col != '0);
        n_op.cv2 = !out_wrap;
        n_op.last = last;
        n_op.pix = done ? 24'd0 : {i_data.blue_in, i_data.green_in, i_data.red_in};
        if (proc) begin
            if (in_wrap) begin
                n_in_col = '0;
                if (r_in_row < rgbc_pkg::ROW_CAP) n_in_row = r_in_row + 11'd1;
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            if (primed) begin
                if (last) begin
                    n_in_col = '0;
                    n_in_row = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (out_wrap) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 10'd1;
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_credit <= '0;
            r_op <= '0;
        end else begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_op <= n_op;
            r_credit <= r_credit + KW'(proc && primed) - KW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= r_in_col;
    end

    assign o_rd_en = proc;
    assign o_rd_addr = r_in_col;
    assign o_op = r_op;
    assign o_col = r_col;
    assign o_credit = r_credit;

endmodule

[hw/rtl/rgbc_back.sv]
module rgbc_back #(
    parameter int LINE_MAX = rgbc_pkg::LINE_MAX_DEF,
    parameter int CW = $clog2(LINE_MAX)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rgbc_pkg::t_op    i_op,
    input  logic [CW-1:0]    i_col,
    input  logic [47:0]      i_rd_data,
    input  logic [47:0]      i_coef_top,
    input  logic [47:0]      i_coef_mid,
    input  logic [47:0]      i_coef_bottom,
    output logic             o_wr_en,
    output logic [CW-1:0]    o_wr_addr,
    output logic [47:0]      o_wr_data,
    output logic             o_push,
    output rgbc_pkg::t_out   o_res
);

    localparam int K = rgbc_pkg::KERNEL;

    logic [23:0]        r_win [K][K];
    logic [23:0]        n_win [K][K];
    logic [23:0]        up, mid;

    logic               r_a_vld, r_a_last;
    logic [23:0]        r_a_win [K][K];
    logic [K*K-1:0]     r_a_msk, n_msk;

    logic               r_b_vld, r_b_last;
    logic signed [24:0] r_b_prod [3][K][K];

    logic               r_c_vld, r_c_last;
    logic signed [26:0] r_c_sum [3][K];

    logic [47:0]        rows [K];
    logic signed [27:0] total [3];
    logic [7:0]         chan [3];

    assign up = i_rd_data[47:24];
    assign mid = i_rd_data[23:0];
    assign o_wr_en = i_op.proc;
    assign o_wr_addr = i_col;
    assign o_wr_data = {mid, i_op.pix};

    always_comb begin
        for (int r = 0; r < K; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = up;
        n_win[1][2] = mid;
        n_win[2][2] = i_op.pix;
        for (int r = 0; r < K; r++) begin
            for (int c = 0; c < K; c++) begin
                n_msk[r*K+c] = ((r == 0) ? i_op.rv0 : (r == 2) ? i_op.rv2 : 1'b1)
                             && ((c == 0) ? i_op.cv0 : (c == 2) ? i_op.cv2 : 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < K; r++) begin
                for (int c = 0; c < K; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_op.proc) begin
            r_win <= n_win;
        end
    end

    assign rows[0] = i_coef_top;
    assign rows[1] = i_coef_mid;
    assign rows[2] = i_coef_bottom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_op.proc && i_op.primed;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_win <= n_win;
        r_a_msk <= n_msk;
        r_a_last <= i_op.last;
        r_b_last <= r_a_last;
        r_c_last <= r_b_last;
        for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < K; r++) begin
                for (int c = 0; c < K; c++) begin
                    // masked taps are the zero padding outside the frame
                    r_b_prod[ch][r][c] <= r_a_msk[r*K+c]
                        ? $signed({1'b0, r_a_win[r][c][8*ch +: 8]})
                          * $signed(rows[r][16*c +: 16])
                        : 25'sd0;
                end
                r_c_sum[ch][r] <= 27'(r_b_prod[ch][r][0]) + 27'(r_b_prod[ch][r][1])
                                + 27'(r_b_prod[ch][r][2]);
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            total[ch] = 28'(r_c_sum[ch][0]) + 28'(r_c_sum[ch][1]) + 28'(r_c_sum[ch][2]);
            if (total[ch] <= 28'sd0) chan[ch] = 8'd0;
            else if (total[ch][27:8] > 20'(rgbc_pkg::PIXEL_MAX))
                chan[ch] = 8'(rgbc_pkg::PIXEL_MAX);
            else chan[ch] = total[ch][15:8];
        end
    end

    assign o_push = r_c_vld;
    assign o_res.red_out = chan[0];
    assign o_res.green_out = chan[1];
    assign o_res.blue_out = chan[2];
    assign o_res.frame_end = r_c_last;

endmodule

[hw/rtl/rgbc_queue.sv]
module rgbc_queue #(
    parameter int DEPTH = rgbc_pkg::QUEUE_DEPTH_DEF,
    parameter int PW = $clog2(DEPTH),
    parameter int KW = $clog2(DEPTH + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rgbc_pkg::t_out i_data,
    input  logic           i_pop,
    output logic           o_valid,
    output rgbc_pkg::t_out o_data
);

    rgbc_pkg::t_out r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [KW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (i_pop) r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            r_cnt <= r_cnt + KW'(i_push) - KW'(i_pop);
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data = r_mem[r_rp];

endmodule

[hw/rtl/rgb_convolution_3x3.sv]
// A result reaches o_valid through the front's op register, the back's stage registers
// a, b and c and the output queue; item k+width+1 of the frame completes output pixel k.
// Throughput: one item per cycle; the input stalls only when the 8-entry output queue
// plus the four-stage datapath hold that many pending results.
// Reset (synchronous, active low) clears position counters, window and queue and restores
// the configuration defaults; the line memory holding both buffered lines is not cleared.
module rgb_convolution_3x3 #(
    parameter int LINE_MAX = rgbc_pkg::LINE_MAX_DEF,
    parameter int QUEUE_DEPTH = rgbc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rgbc_pkg::t_in  i_data,
    output logic           o_stall,
    output logic           o_valid,
    output rgbc_pkg::t_out o_data,
    input  logic           i_stall,
    input  logic           i_cfg_wr_en,
    input  logic [2:0]     i_cfg_index,
    input  logic [47:0]    i_cfg_data
);

    localparam int CW = $clog2(LINE_MAX);
    localparam int KW = $clog2(QUEUE_DEPTH + 1);

    logic [10:0]    r_frame_width, r_frame_height;
    logic [47:0]    r_coef_top, r_coef_mid, r_coef_bottom;

    logic           rd_en, wr_en, push, pop;
    logic [CW-1:0]  rd_addr, wr_addr, col;
    logic [47:0]    rd_data, wr_data;
    logic [KW-1:0]  credit;
    rgbc_pkg::t_op  op;
    rgbc_pkg::t_out res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= rgbc_pkg::FRAME_WIDTH_RST;
            r_frame_height <= rgbc_pkg::FRAME_HEIGHT_RST;
            r_coef_top <= rgbc_pkg::COEF_TOP_RST;
            r_coef_mid <= rgbc_pkg::COEF_MID_RST;
            r_coef_bottom <= rgbc_pkg::COEF_BOTTOM_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                rgbc_pkg::REG_FRAME_WIDTH: r_frame_width <= i_cfg_data[10:0];
                rgbc_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[10:0];
                rgbc_pkg::REG_COEF_TOP: r_coef_top <= i_cfg_data;
                rgbc_pkg::REG_COEF_MID: r_coef_mid <= i_cfg_data;
                rgbc_pkg::REG_COEF_BOTTOM: r_coef_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign pop = o_valid && !i_stall;

    rgbc_front #(.LINE_MAX(LINE_MAX), .QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_data(i_data), .o_stall(o_stall), .i_pop(pop),
        .i_frame_width(r_frame_width), .i_frame_height(r_frame_height),
        .o_rd_en(rd_en), .o_rd_addr(rd_addr), .o_op(op), .o_col(col),
        .o_credit(credit)
    );

    rgbc_line_mem #(.DEPTH(LINE_MAX)) u_line_mem (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_rd_en(rd_en), .i_rd_addr(rd_addr),
        .i_wr_en(wr_en), .i_wr_addr(wr_addr), .i_wr_data(wr_data),
        .o_rd_data(rd_data)
    );

    rgbc_back #(.LINE_MAX(LINE_MAX)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_op(op), .i_col(col), .i_rd_data(rd_data),
        .i_coef_top(r_coef_top), .i_coef_mid(r_coef_mid), .i_coef_bottom(r_coef_bottom),
        .o_wr_en(wr_en), .o_wr_addr(wr_addr), .o_wr_data(wr_data),
        .o_push(push), .o_res(res)
    );

    rgbc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(res), .i_pop(pop),
        .o_valid(o_valid), .o_data(o_data)
    );

    // pending results never exceed the queue room
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        credit <= KW'(QUEUE_DEPTH))
        else $error("result credit exceeds queue depth");

    // a result on the output is always accounted for
    a_valid_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (credit != '0))
        else $error("output valid without pending credit");

    // results enter the queue only while credit is held for them
    a_push_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (credit != '0))
        else $error("queue push without credit");

endmodule
